// ===== design/psgrwd_pkg.sv =====
// psgrwd_pkg: shared constants and types for the psg register write decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package psgrwd_pkg;

    localparam int NUM_CHIPS    = 4;
    localparam int CHAN_PER_CHIP = 4;
    localparam int NUM_SLOTS    = NUM_CHIPS * CHAN_PER_CHIP;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int CHIP_IDX_W   = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;

    localparam int CHIP_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int CHAN_W   = 2;
    localparam int REG_W    = 3;
    localparam int PERIOD_W = 10;
    localparam int VOLUME_W = 4;

    // write byte layout
    localparam int LATCH_BIT = 7;

    typedef struct packed {
        logic [CHIP_W-1:0]   chip_index;
        logic [CHAN_W-1:0]   channel_index;
        logic                volume_written;
        logic [PERIOD_W-1:0] channel_period;
        logic [VOLUME_W-1:0] channel_volume;
    } t_result;

endpackage

`default_nettype wire

// ===== design/psgrwd_in_stage.sv =====
// psgrwd_in_stage: input register for one write transaction
// uses psgrwd_pkg; handed on when the downstream stage advances
`timescale 1ns / 1ps
`default_nettype none

module psgrwd_in_stage
    import psgrwd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [CHIP_W-1:0] i_chip_select,
    input  wire logic [BYTE_W-1:0] i_write_byte,
    input  wire logic              i_advance,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [CHIP_W-1:0]      o_chip,
    output logic [BYTE_W-1:0]      o_byte
);

    logic              r_valid;
    logic [CHIP_W-1:0] r_chip;
    logic [BYTE_W-1:0] r_byte;

    // full and the next stage cannot take it
    assign o_stall = r_valid && !i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_chip <= i_chip_select;
            r_byte <= i_write_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_chip  = r_chip;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// ===== design/psgrwd_reg_file.sv =====
// psgrwd_reg_file: latched register, period and volume stores with the byte decode
// uses psgrwd_pkg; state commits when the transaction moves to the output register
`timescale 1ns / 1ps
`default_nettype none

module psgrwd_reg_file
    import psgrwd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_commit,
    input  wire logic [CHIP_W-1:0] i_chip,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_result                o_result
);

    logic [REG_W-1:0]    r_latch  [NUM_CHIPS];
    logic [PERIOD_W-1:0] r_period [NUM_SLOTS];
    logic [VOLUME_W-1:0] r_volume [NUM_SLOTS];

    logic [PERIOD_W-1:0] n_period;
    logic [VOLUME_W-1:0] n_volume;

    logic                  chip_ok;
    logic                  is_latch;
    logic [REG_W-1:0]      sel_reg;
    logic [CHAN_W-1:0]     chan;
    logic                  vol_sel;
    logic [CHIP_IDX_W-1:0] chip_idx;
    logic [SLOT_W-1:0]     slot;
    logic [PERIOD_W-1:0]   cur_period;

    assign chip_ok  = int'(i_chip) < NUM_CHIPS;
    assign chip_idx = CHIP_IDX_W'(i_chip);
    assign is_latch = i_byte[LATCH_BIT];
    assign sel_reg  = is_latch ? i_byte[6:4] : r_latch[chip_idx];
    assign chan     = sel_reg[2:1];
    assign vol_sel  = sel_reg[0];
    assign slot     = SLOT_W'({i_chip, chan});
    assign cur_period = r_period[slot];

    always_comb begin
        n_period = cur_period;
        n_volume = r_volume[slot];
        if (vol_sel) begin
            n_volume = i_byte[3:0];
        end else if (is_latch) begin
            n_period = {cur_period[9:4], i_byte[3:0]};
        end else begin
            // data byte: bit 6 is dropped
            n_period = {i_byte[5:0], cur_period[3:0]};
        end
    end

    always_comb begin
        o_result = '0;
        o_result.chip_index = i_chip;
        if (chip_ok) begin
            o_result.channel_index  = chan;
            o_result.volume_written = vol_sel;
            o_result.channel_period = n_period;
            o_result.channel_volume = n_volume;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHIPS; k++) begin
                r_latch[k] <= '0;
            end
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_period[k] <= '0;
                r_volume[k] <= '0;
            end
        end else if (i_commit && chip_ok) begin
            if (is_latch) begin
                r_latch[chip_idx] <= i_byte[6:4];
            end
            r_period[slot] <= n_period;
            r_volume[slot] <= n_volume;
        end
    end

endmodule

`default_nettype wire

// ===== design/psgrwd_out_stage.sv =====
// psgrwd_out_stage: result register toward the downstream side
// uses psgrwd_pkg; reports when it can take a new result
`timescale 1ns / 1ps
`default_nettype none

module psgrwd_out_stage
    import psgrwd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_result   i_result,
    input  wire logic i_stall,
    output logic      o_advance,
    output logic      o_valid,
    output t_result   o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== design/psg_register_write_decoder.sv =====
// psg_register_write_decoder: top level of the psg register write decoder
// uses psgrwd_pkg, psgrwd_in_stage, psgrwd_reg_file and psgrwd_out_stage
`timescale 1ns / 1ps
`default_nettype none

// Decodes bytes written to up to four SN76489-style sound chips. Each transaction
// carries a chip select and one byte; a latch byte (bit 7 set) picks the channel
// and register and writes the low nibble, a data byte writes the volume or the
// upper six period bits of the chip's latched register. Every transaction returns
// one result: the channel touched, whether volume was written, and that channel's
// period and volume after the write. An accepted transaction is held in the input
// register, then in the result register; one transaction is taken every cycle
// unless a stall holds it back: the input register feeds a single level of decode
// and store update, which commits as the result register loads. Stores and valids
// clear on reset; an unfitted chip returns only its chip index and changes nothing.
module psg_register_write_decoder
    import psgrwd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [CHIP_W-1:0]   i_chip_select,
    input  wire logic [BYTE_W-1:0]   i_write_byte,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [CHIP_W-1:0]        o_chip_index,
    output logic [CHAN_W-1:0]        o_channel_index,
    output logic                     o_volume_written,
    output logic [PERIOD_W-1:0]      o_channel_period,
    output logic [VOLUME_W-1:0]      o_channel_volume
);

    logic              advance;
    logic              stg_valid;
    logic [CHIP_W-1:0] stg_chip;
    logic [BYTE_W-1:0] stg_byte;
    t_result           dec_result;
    t_result           out_result;

    psgrwd_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_chip_select (i_chip_select),
        .i_write_byte  (i_write_byte),
        .i_advance     (advance),
        .o_stall       (o_stall),
        .o_valid       (stg_valid),
        .o_chip        (stg_chip),
        .o_byte        (stg_byte)
    );

    psgrwd_reg_file u_reg_file (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (stg_valid && advance),
        .i_chip   (stg_chip),
        .i_byte   (stg_byte),
        .o_result (dec_result)
    );

    psgrwd_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stg_valid),
        .i_result  (dec_result),
        .i_stall   (i_stall),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_result  (out_result)
    );

    assign o_chip_index     = out_result.chip_index;
    assign o_channel_index  = out_result.channel_index;
    assign o_volume_written = out_result.volume_written;
    assign o_channel_period = out_result.channel_period;
    assign o_channel_volume = out_result.channel_volume;

endmodule

`default_nettype wire

// ===== bench/psg_register_write_decoder_tb.sv =====
// psg_register_write_decoder_tb: self-checking bench for the psg register write decoder
// drives chip/byte writes, predicts each channel update and checks every result
// depends on psgrwd_pkg and psg_register_write_decoder
`timescale 1ns / 1ps

module psg_register_write_decoder_tb;
    import psgrwd_pkg::*;

    localparam int RANDOM_WRITES  = 1250;
    localparam int MAX_IDLE       = 18;
    localparam int ZERO_GAP_FROM  = 380;   // sender keeps offering across the long hold
    localparam int ZERO_GAP_TO    = 700;
    localparam int HOLD_AT_RESULT = 420;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int TAIL_CYCLES    = 12;
    localparam int MAX_REPORTS    = 60;

    typedef struct {
        logic [CHIP_W-1:0] chip;
        logic [BYTE_W-1:0] data;
        int                gap;
        bit                drain;
    } psg_write_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                drv_valid = 1'b0;
    logic [CHIP_W-1:0]   drv_chip = '0;
    logic [BYTE_W-1:0]   drv_byte = '0;
    logic                rcv_stall = 1'b0;
    logic                dut_stall;
    logic                res_valid;
    logic [CHIP_W-1:0]   res_chip;
    logic [CHAN_W-1:0]   res_channel;
    logic                res_vol_written;
    logic [PERIOD_W-1:0] res_period;
    logic [VOLUME_W-1:0] res_volume;

    // shadow of the chip registers
    logic [REG_W-1:0]    latch_sel  [0:NUM_CHIPS-1];
    logic [PERIOD_W-1:0] period_mem [0:NUM_SLOTS-1];
    logic [VOLUME_W-1:0] volume_mem [0:NUM_SLOTS-1];

    psg_write_t pending_writes[$];
    t_result    expected_updates[$];
    psg_write_t staged;
    bit         have_staged = 1'b0;
    int         gap_left = 0;
    int         n_writes = 0;
    int         n_checked = 0;
    int         n_errors = 0;
    int         wait_left = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         idle_cycles = 0;

    psg_register_write_decoder u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (drv_valid),
        .o_stall          (dut_stall),
        .i_chip_select    (drv_chip),
        .i_write_byte     (drv_byte),
        .o_valid          (res_valid),
        .i_stall          (rcv_stall),
        .o_chip_index     (res_chip),
        .o_channel_index  (res_channel),
        .o_volume_written (res_vol_written),
        .o_channel_period (res_period),
        .o_channel_volume (res_volume)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_result apply_psg_write(input logic [CHIP_W-1:0] chip,
                                                input logic [BYTE_W-1:0] wr);
        t_result          upd;
        logic [REG_W-1:0] sel;
        int               slot;
        upd = '0;
        upd.chip_index = chip;
        if (chip >= NUM_CHIPS)
            return upd;
        if (wr[LATCH_BIT]) begin
            sel = wr[6:4];
            latch_sel[chip] = sel;
        end else begin
            sel = latch_sel[chip];
        end
        slot = chip * CHAN_PER_CHIP + sel[2:1];
        if (sel[0])
            volume_mem[slot] = wr[3:0];
        else if (wr[LATCH_BIT])
            period_mem[slot][3:0] = wr[3:0];
        else
            period_mem[slot][9:4] = wr[5:0];
        upd.channel_index  = sel[2:1];
        upd.volume_written = sel[0];
        upd.channel_period = period_mem[slot];
        upd.channel_volume = volume_mem[slot];
        return upd;
    endfunction

    function automatic int draw_idle(input int idx);
        case ((idx / 120) % 3)
            0: return 0;
            1: return $urandom_range(MAX_IDLE);
            default: return ($urandom_range(3) == 0) ? $urandom_range(MAX_IDLE) : 0;
        endcase
    endfunction

    task automatic queue_write(input logic [CHIP_W-1:0] chip, input logic [BYTE_W-1:0] wr);
        psg_write_t w;
        w.chip  = chip;
        w.data  = wr;
        w.gap   = (n_writes >= ZERO_GAP_FROM && n_writes <= ZERO_GAP_TO) ? 0 : draw_idle(n_writes);
        w.drain = (n_writes == 25 || n_writes == 900);
        pending_writes.push_back(w);
        n_writes++;
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            if (n_errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // driver: one transaction offered at a time, payload held while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (!(drv_valid && dut_stall)) begin
            if (drv_valid)
                expected_updates.push_back(apply_psg_write(drv_chip, drv_byte));
            if (!have_staged && pending_writes.size() != 0
                && !(pending_writes[0].drain && expected_updates.size() != 0)) begin
                staged      = pending_writes.pop_front();
                gap_left    = staged.gap;
                have_staged = 1'b1;
            end
            if (have_staged && gap_left == 0) begin
                drv_valid   <= 1'b1;
                drv_chip    <= staged.chip;
                drv_byte    <= staged.data;
                have_staged = 1'b0;
            end else begin
                if (have_staged)
                    gap_left--;
                drv_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result and stalls the output at random
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            rcv_stall <= 1'b0;
        end else begin
            if (res_valid && !rcv_stall) begin
                if (expected_updates.size() == 0) begin
                    if (n_errors < MAX_REPORTS)
                        $display("%0t: unexpected transaction, expected none, actual chip %0d",
                                 $time, res_chip);
                    n_errors++;
                end else begin
                    want = expected_updates.pop_front();
                    report_field("chip_index", want.chip_index, res_chip);
                    report_field("channel_index", want.channel_index, res_channel);
                    report_field("volume_written", want.volume_written, res_vol_written);
                    report_field("channel_period", want.channel_period, res_period);
                    report_field("channel_volume", want.channel_volume, res_volume);
                end
                n_checked++;
                wait_left = draw_idle(n_checked + 60);
                if (n_checked == HOLD_AT_RESULT && !hold_done) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rcv_stall <= 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                rcv_stall <= 1'b1;
            end else begin
                rcv_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (drv_valid && !dut_stall) || (res_valid && !rcv_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[psg_register_write_decoder] ERROR");
            $finish;
        end
    end

    initial begin
        int         k;
        logic [1:0] chip;
        for (int i = 0; i < NUM_CHIPS; i++)
            latch_sel[i] = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            period_mem[i] = '0;
            volume_mem[i] = '0;
        end

        // data bytes before any latch go to channel 0 period
        queue_write(2'd0, 8'h00);
        queue_write(2'd0, 8'h7F);
        queue_write(2'd0, 8'h8F);
        queue_write(2'd0, 8'h3F);
        queue_write(2'd0, 8'h9F);
        queue_write(2'd0, 8'h40);   // bit 6 ignored on a volume data byte
        queue_write(2'd1, 8'hA0);
        queue_write(2'd1, 8'h00);
        queue_write(2'd1, 8'hBF);
        queue_write(2'd1, 8'h0F);
        queue_write(2'd2, 8'hC5);
        queue_write(2'd2, 8'h7A);   // bit 6 ignored on a period data byte
        queue_write(2'd2, 8'hD0);
        queue_write(2'd2, 8'h7F);
        queue_write(2'd3, 8'hE7);   // noise control
        queue_write(2'd3, 8'h3F);
        queue_write(2'd3, 8'hFF);
        queue_write(2'd3, 8'h00);
        queue_write(2'd3, 8'hE0);
        queue_write(2'd3, 8'h40);
        queue_write(2'd1, 8'h8A);
        queue_write(2'd2, 8'hF3);
        queue_write(2'd0, 8'h80);
        queue_write(2'd3, 8'h15);
        queue_write(2'd1, 8'h6C);

        // mostly latch + data sequences, some interleaved or stray writes
        while (n_writes < RANDOM_WRITES + 25) begin
            chip = CHIP_W'($urandom_range(3));
            if ($urandom_range(9) < 8) begin
                queue_write(chip, 8'h80 | BYTE_W'($urandom_range(127)));
                k = $urandom_range(3);
                for (int j = 0; j < k; j++) begin
                    if ($urandom_range(7) == 0)
                        queue_write(CHIP_W'($urandom_range(3)), BYTE_W'($urandom_range(255)));
                    queue_write(chip, BYTE_W'($urandom_range(127)));
                end
            end else begin
                queue_write(chip, BYTE_W'($urandom_range(255)));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (pending_writes.size() != 0 || have_staged || drv_valid
               || expected_updates.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0 && expected_updates.size() == 0)
            $display("[psg_register_write_decoder] OK");
        else
            $display("[psg_register_write_decoder] ERROR");
        $finish;
    end

endmodule
